/* src/crpe_pkg.sv */
// ----------------------------------------------------------------------------
// crpe_pkg: shared types, codes and tables
// Item and result layouts, bus offsets, indexed register numbers, gain and
// rate tables for the register playback codec.
// ----------------------------------------------------------------------------
package crpe_pkg;

    localparam int REG_COUNT  = 16;
    localparam int GAIN_STEPS = 64;
    localparam int IDX_W      = $clog2(REG_COUNT);
    localparam int GAIN_W     = $clog2(GAIN_STEPS);

    // actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // bus offsets (0..3 all map to the config byte)
    localparam logic [2:0] OFF_INDEX  = 3'd4;
    localparam logic [2:0] OFF_DATA   = 3'd5;
    localparam logic [2:0] OFF_STATUS = 3'd6;

    // indexed registers with side effects
    localparam logic [IDX_W-1:0] IDX_LGAIN  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_RGAIN  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_FORMAT = 4'd8;
    localparam logic [IDX_W-1:0] IDX_CTRL   = 4'd9;
    localparam logic [IDX_W-1:0] IDX_IRQ_EN = 4'd10;
    localparam logic [IDX_W-1:0] IDX_RO     = 4'd12;
    localparam logic [IDX_W-1:0] IDX_CNT_HI = 4'd14;
    localparam logic [IDX_W-1:0] IDX_CNT_LO = 4'd15;

    // frame formats, format register bits 6:4
    localparam logic [2:0] FMT_MONO8    = 3'b000;
    localparam logic [2:0] FMT_STEREO8  = 3'b001;
    localparam logic [2:0] FMT_MONO16   = 3'b100;
    localparam logic [2:0] FMT_STEREO16 = 3'b101;

    localparam logic [7:0]  STATUS_INIT = 8'hcc;
    localparam logic [7:0]  READ_IDLE   = 8'hff;
    localparam logic [7:0]  SIGN_FLIP   = 8'h80;
    localparam logic [7:0]  CTRL_MASK   = 8'h41;
    localparam logic [7:0]  CTRL_RUN    = 8'h01;
    localparam logic [7:0]  CFG_ID      = 8'h04;
    localparam logic [7:0]  CFG_ID_MASK = 8'h40;
    localparam logic [16:0] PHASE_MAX   = 17'h1ffff;
    localparam logic [3:0]  IRQ_INIT    = 4'd7;
    localparam logic [1:0]  DMA_INIT    = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  offset;
        logic [7:0]  write_data;
        logic [31:0] dma_data;
    } item_t;

    typedef struct packed {
        logic [7:0]         read_data;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [2:0]         dma_bytes_used;
        logic               irq_pulse;
        logic [3:0]         irq_number;
        logic [1:0]         dma_channel;
    } result_t;

    function automatic logic [7:0] reg_init(input logic [IDX_W-1:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: v = 8'h80;
            4'd9:                               v = 8'h08;
            4'd12:                              v = 8'h0a;
            default:                            v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] dma_map(input logic [1:0] sel);
        logic [1:0] v;
        unique case (sel)
            2'd0:    v = 2'd0;
            2'd1:    v = 2'd0;
            2'd2:    v = 2'd1;
            default: v = 2'd3;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] irq_map(input logic [2:0] sel);
        logic [3:0] v;
        unique case (sel)
            3'd0:    v = 4'd5;
            3'd1:    v = 4'd7;
            3'd2:    v = 4'd9;
            3'd3:    v = 4'd10;
            3'd4:    v = 4'd11;
            3'd5:    v = 4'd12;
            3'd6:    v = 4'd14;
            default: v = 4'd15;
        endcase
        return v;
    endfunction

    // key = {divisor select, crystal select}; 1.16 step per output tick
    function automatic logic [16:0] rate_lookup(input logic [3:0] key);
        logic [16:0] v;
        unique case (key)
            4'h0: v = 17'd10922;
            4'h1: v = 17'd7526;
            4'h2: v = 17'd21845;
            4'h3: v = 17'd15052;
            4'h4: v = 17'd37449;
            4'h5: v = 17'd25804;
            4'h6: v = 17'd43690;
            4'h7: v = 17'd30105;
            4'h8: v = 17'd74898;
            4'h9: v = 17'd51609;
            4'ha: v = 17'd87381;
            4'hb: v = 17'd60211;
            4'hc: v = 17'd65536;
            4'hd: v = 17'd45158;
            4'he: v = 17'd13107;
            4'hf: v = 17'd9031;
        endcase
        return v;
    endfunction

    // attenuation in 3 dB steps, 16-bit fraction
    function automatic logic [16:0] gain_lookup(input logic [GAIN_W-1:0] step);
        logic [16:0] v;
        unique case (step)
            6'd0:    v = 17'd65536;
            6'd1:    v = 17'd46395;
            6'd2:    v = 17'd32845;
            6'd3:    v = 17'd23253;
            6'd4:    v = 17'd16461;
            6'd5:    v = 17'd11654;
            6'd6:    v = 17'd8250;
            6'd7:    v = 17'd5840;
            6'd8:    v = 17'd4135;
            6'd9:    v = 17'd2927;
            6'd10:   v = 17'd2072;
            6'd11:   v = 17'd1467;
            6'd12:   v = 17'd1038;
            6'd13:   v = 17'd735;
            6'd14:   v = 17'd520;
            6'd15:   v = 17'd368;
            6'd16:   v = 17'd260;
            6'd17:   v = 17'd184;
            6'd18:   v = 17'd130;
            6'd19:   v = 17'd92;
            6'd20:   v = 17'd65;
            6'd21:   v = 17'd46;
            6'd22:   v = 17'd32;
            6'd23:   v = 17'd23;
            6'd24:   v = 17'd16;
            6'd25:   v = 17'd11;
            6'd26:   v = 17'd8;
            6'd27:   v = 17'd5;
            6'd28:   v = 17'd4;
            6'd29:   v = 17'd2;
            6'd30:   v = 17'd2;
            6'd31:   v = 17'd1;
            6'd32:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/crpe_scaler.sv */
// ----------------------------------------------------------------------------
// crpe_scaler: one channel of output gain
// Multiplies a held sample by the ROM gain of its gain register, floors the
// 16.16 product, or returns zero when the mute bit is set.
// ----------------------------------------------------------------------------
module crpe_scaler (
    input  logic [15:0]        held,
    input  logic [7:0]         gain_reg,
    output logic signed [15:0] scaled
);

    logic [16:0]        gain;
    logic signed [33:0] prod;

    assign gain = crpe_pkg::gain_lookup(gain_reg[crpe_pkg::GAIN_W-1:0]);
    assign prod = $signed(held) * $signed({1'b0, gain});

    // bits 31:16 of the product are the floor of prod / 2^16
    assign scaled = gain_reg[7] ? 16'sd0 : prod[31:16];

endmodule

/* src/crpe_core.sv */
// ----------------------------------------------------------------------------
// crpe_core: codec register state and per-word processing
// Holds the bus registers, indexed registers, phase accumulator and sample
// counter; computes one result from one word and updates state on en.
// ----------------------------------------------------------------------------
module crpe_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  crpe_pkg::item_t   item,
    output crpe_pkg::result_t res
);

    localparam int IW = crpe_pkg::IDX_W;

    logic [7:0]  config_reg,  config_next;
    logic [IW-1:0] index_reg, index_next;
    logic        xfer_reg,    xfer_next;
    logic        mce_reg,     mce_next;
    logic [7:0]  status_reg,  status_next;
    logic [16:0] count_reg,   count_next;
    logic [15:0] lheld_reg,   lheld_next;
    logic [15:0] rheld_reg,   rheld_next;
    logic [16:0] phase_reg,   phase_next;
    logic [16:0] rate_reg,    rate_next;
    logic        run_reg,     run_next;
    logic [3:0]  irq_reg,     irq_next;
    logic [1:0]  dma_reg,     dma_next;
    logic [7:0]  regs_reg [crpe_pkg::REG_COUNT];

    logic        wr_en;
    logic        is_tick;
    logic [17:0] phase_sum;
    logic [16:0] phase_sat;
    logic [16:0] count_base;
    logic [7:0]  b0, b1, b2, b3;
    logic [7:0]  v;
    logic signed [15:0] left_s, right_s;

    crpe_scaler u_left (
        .held     (lheld_reg),
        .gain_reg (regs_reg[crpe_pkg::IDX_LGAIN]),
        .scaled   (left_s)
    );

    crpe_scaler u_right (
        .held     (rheld_reg),
        .gain_reg (regs_reg[crpe_pkg::IDX_RGAIN]),
        .scaled   (right_s)
    );

    assign v  = item.write_data;
    assign b0 = item.dma_data[7:0];
    assign b1 = item.dma_data[15:8];
    assign b2 = item.dma_data[23:16];
    assign b3 = item.dma_data[31:24];

    assign is_tick    = (item.action == crpe_pkg::ACT_TICK) && run_reg;
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, rate_reg};
    assign phase_sat  = phase_sum[17] ? crpe_pkg::PHASE_MAX : phase_sum[16:0];
    assign count_base = count_reg[16]
                      ? {1'b0, regs_reg[crpe_pkg::IDX_CNT_HI], regs_reg[crpe_pkg::IDX_CNT_LO]}
                      : count_reg;

    always_comb
    begin
        config_next = config_reg;
        index_next  = index_reg;
        xfer_next   = xfer_reg;
        mce_next    = mce_reg;
        status_next = status_reg;
        count_next  = count_reg;
        lheld_next  = lheld_reg;
        rheld_next  = rheld_reg;
        phase_next  = phase_reg;
        rate_next   = rate_reg;
        run_next    = run_reg;
        irq_next    = irq_reg;
        dma_next    = dma_reg;
        wr_en       = 1'b0;

        res                = '0;
        res.read_data      = crpe_pkg::READ_IDLE;

        unique case (item.action)
            crpe_pkg::ACT_READ:
            begin
                unique if (item.offset[2] == 1'b0)
                    res.read_data = crpe_pkg::CFG_ID | (config_reg & crpe_pkg::CFG_ID_MASK);
                else if (item.offset == crpe_pkg::OFF_INDEX)
                    res.read_data = {1'b0, mce_reg, xfer_reg, 1'b0, index_reg};
                else if (item.offset == crpe_pkg::OFF_DATA)
                    res.read_data = regs_reg[index_reg];
                else if (item.offset == crpe_pkg::OFF_STATUS)
                    res.read_data = status_reg;
                else
                    res.read_data = crpe_pkg::READ_IDLE;
            end
            crpe_pkg::ACT_WRITE:
            begin
                unique if (item.offset[2] == 1'b0)
                begin
                    config_next = v;
                    dma_next    = crpe_pkg::dma_map(v[1:0]);
                    irq_next    = crpe_pkg::irq_map(v[5:3]);
                end
                else if (item.offset == crpe_pkg::OFF_INDEX)
                begin
                    index_next = v[IW-1:0];
                    xfer_next  = v[5];
                    mce_next   = v[6];
                end
                else if (item.offset == crpe_pkg::OFF_DATA)
                begin
                    wr_en = (index_reg != crpe_pkg::IDX_RO);
                    if (index_reg == crpe_pkg::IDX_FORMAT)
                        rate_next = crpe_pkg::rate_lookup(v[3:0]);
                    if (index_reg == crpe_pkg::IDX_CTRL)
                    begin
                        if (!run_reg)
                            phase_next = '0;
                        run_next = ((v & crpe_pkg::CTRL_MASK) == crpe_pkg::CTRL_RUN);
                    end
                    if (index_reg == crpe_pkg::IDX_CNT_HI)
                        count_next = {1'b0, v, regs_reg[crpe_pkg::IDX_CNT_LO]};
                end
                else if (item.offset == crpe_pkg::OFF_STATUS)
                    status_next[0] = 1'b0;
                else
                begin
                    // spare offset: write dropped
                end
            end
            default:
            begin
                if (is_tick)
                begin
                    res.left_out  = left_s;
                    res.right_out = right_s;
                    phase_next    = phase_sat;
                    if (phase_sat[16])
                    begin
                        phase_next = {1'b0, phase_sat[15:0]};
                        // counter ran out: reload and flag the interrupt
                        if (count_reg[16] && !status_reg[0])
                        begin
                            status_next[0] = 1'b1;
                            res.irq_pulse  = regs_reg[crpe_pkg::IDX_IRQ_EN][1];
                        end
                        count_next = count_base - 17'd1;
                        unique case (regs_reg[crpe_pkg::IDX_FORMAT][6:4])
                            crpe_pkg::FMT_MONO8:
                            begin
                                lheld_next = {b0 ^ crpe_pkg::SIGN_FLIP, 8'h00};
                                rheld_next = {b0 ^ crpe_pkg::SIGN_FLIP, 8'h00};
                                res.dma_bytes_used = 3'd1;
                            end
                            crpe_pkg::FMT_STEREO8:
                            begin
                                lheld_next = {b0 ^ crpe_pkg::SIGN_FLIP, 8'h00};
                                rheld_next = {b1 ^ crpe_pkg::SIGN_FLIP, 8'h00};
                                res.dma_bytes_used = 3'd2;
                            end
                            crpe_pkg::FMT_MONO16:
                            begin
                                lheld_next = {b0, b1};
                                rheld_next = {b0, b1};
                                res.dma_bytes_used = 3'd2;
                            end
                            crpe_pkg::FMT_STEREO16:
                            begin
                                lheld_next = {b0, b1};
                                rheld_next = {b2, b3};
                                res.dma_bytes_used = 3'd4;
                            end
                            default:
                            begin
                                // unknown format: nothing fetched
                            end
                        endcase
                    end
                end
            end
        endcase

        res.irq_number  = irq_next;
        res.dma_channel = dma_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            config_reg <= '0;
            index_reg  <= '0;
            xfer_reg   <= 1'b0;
            mce_reg    <= 1'b1;
            status_reg <= crpe_pkg::STATUS_INIT;
            count_reg  <= '0;
            lheld_reg  <= '0;
            rheld_reg  <= '0;
            phase_reg  <= '0;
            rate_reg   <= '0;
            run_reg    <= 1'b0;
            irq_reg    <= crpe_pkg::IRQ_INIT;
            dma_reg    <= crpe_pkg::DMA_INIT;
            for (int i = 0; i < crpe_pkg::REG_COUNT; i++)
            begin
                regs_reg[i] <= crpe_pkg::reg_init(IW'(i));
            end
        end
        else if (en)
        begin
            config_reg <= config_next;
            index_reg  <= index_next;
            xfer_reg   <= xfer_next;
            mce_reg    <= mce_next;
            status_reg <= status_next;
            count_reg  <= count_next;
            lheld_reg  <= lheld_next;
            rheld_reg  <= rheld_next;
            phase_reg  <= phase_next;
            rate_reg   <= rate_next;
            run_reg    <= run_next;
            irq_reg    <= irq_next;
            dma_reg    <= dma_next;
            if (wr_en)
                regs_reg[index_reg] <= v;
        end
    end

endmodule

/* src/codec_register_playback_engine.sv */
// ----------------------------------------------------------------------------
// codec_register_playback_engine: register playback codec top level
// Pipeline: two register stages (input register, then result register); an
// input word is held in the input register, passes once through the core and
// is registered as its result. One word per cycle while the output is not stalled.
// Reset: async active low; bus and indexed registers take their init values,
// the playback engine is stopped and both pipeline registers are empty.
// ----------------------------------------------------------------------------
module codec_register_playback_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // offset[2:0], write_data[10:3], dma_data[42:11], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // read_data[7:0], left_out[23:8], right_out[39:24],
                                   // dma_bytes_used[42:40], irq_pulse[43],
                                   // irq_number[47:44], dma_channel[49:48], zero pad
);

    crpe_pkg::item_t   in_reg;
    crpe_pkg::result_t out_reg;
    crpe_pkg::result_t res;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    crpe_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_reg.action     <= s_tuser;
            in_reg.offset     <= s_tdata[2:0];
            in_reg.write_data <= s_tdata[10:3];
            in_reg.dma_data   <= s_tdata[42:11];
        end
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.dma_channel, out_reg.irq_number, out_reg.irq_pulse,
                       out_reg.dma_bytes_used, out_reg.right_out, out_reg.left_out,
                       out_reg.read_data};

    // a frame is one, two or four bytes
    a_used_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[42:40] == 3'd0 || m_tdata[42:40] == 3'd1 ||
                      m_tdata[42:40] == 3'd2 || m_tdata[42:40] == 3'd4))
        else $error("dma_bytes_used out of range");

    // a fetching tick never returns bus read data
    a_fetch_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[42:40] != 3'd0) |-> (m_tdata[7:0] == crpe_pkg::READ_IDLE))
        else $error("fetch result carries read data");

    // a waiting input word is not dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word lost while stalled");

endmodule

/* sim/crpe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_checker: response checker for the register playback codec
// Watches both stream channels. Every accepted input word runs through a
// cycle-free model of the codec (bus registers, indexed registers, phase
// accumulator, frame fetch, gain scaling) and its response is queued. Every
// accepted output word is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module crpe_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          mismatches,
    output int          awaited
);

    localparam int PHASE_ONE   = 'h10000;
    localparam int COUNT_FLOOR = -65536;
    localparam int XTAL_A      = 24576000;
    localparam int XTAL_B      = 16934400;
    localparam int OUT_RATE    = 48000;

    int         div_tab[8]     = '{3072, 1536, 896, 768, 448, 384, 512, 2560};
    logic [1:0] dma_tab[4]     = '{2'd0, 2'd0, 2'd1, 2'd3};
    logic [3:0] irq_tab[8]     = '{4'd5, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd14, 4'd15};
    logic [7:0] reg_boot[16]   = '{8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                                   8'h00, 8'h08, 8'h00, 8'h00, 8'h0a, 8'h00, 8'h00, 8'h00};
    int         gain_tab[crpe_pkg::GAIN_STEPS];

    // codec state as seen by the bus and the playback engine
    logic [7:0]  bus_cfg;
    logic [3:0]  sel_index;
    logic        xfer_bit;
    logic        mce_bit;
    logic [7:0]  ireg[crpe_pkg::REG_COUNT];
    logic [7:0]  status;
    int          frames_left;
    logic [15:0] hold_l;
    logic [15:0] hold_r;
    int          phase;
    int          step;
    logic        playing;
    logic [3:0]  irq_line;
    logic [1:0]  dma_line;

    crpe_pkg::result_t pending_responses[$];

    initial begin
        // 3 dB attenuation steps as a 16-bit fraction, truncated
        for (int c = 0; c < crpe_pkg::GAIN_STEPS; c++)
            gain_tab[c] = int'($floor(65536.0 * (10.0 ** (-0.15 * c))));
    end

    function automatic logic [15:0] scaled(input logic [15:0] held, input logic [7:0] greg);
        logic signed [47:0] prod;
        if (greg[7])
            return 16'h0000;
        prod = $signed(held) * gain_tab[greg[5:0]];
        // floor division by 2^16
        return prod[31:16];
    endfunction

    function automatic crpe_pkg::result_t codec_response(input logic [1:0] act,
                                                         input logic [2:0] off,
                                                         input logic [7:0] wd,
                                                         input logic [31:0] dd);
        crpe_pkg::result_t r;
        int      acc;
        longint  xtal;
        r = '0;
        r.read_data = crpe_pkg::READ_IDLE;
        case (act)
            crpe_pkg::ACT_READ:
            begin
                if (off < crpe_pkg::OFF_INDEX)
                    r.read_data = crpe_pkg::CFG_ID | (bus_cfg & crpe_pkg::CFG_ID_MASK);
                else if (off == crpe_pkg::OFF_INDEX)
                    r.read_data = {1'b0, mce_bit, xfer_bit, 1'b0, sel_index};
                else if (off == crpe_pkg::OFF_DATA)
                    r.read_data = ireg[sel_index];
                else if (off == crpe_pkg::OFF_STATUS)
                    r.read_data = status;
            end
            crpe_pkg::ACT_WRITE:
            begin
                if (off < crpe_pkg::OFF_INDEX) begin
                    bus_cfg  = wd;
                    dma_line = dma_tab[wd[1:0]];
                    irq_line = irq_tab[wd[5:3]];
                end else if (off == crpe_pkg::OFF_INDEX) begin
                    sel_index = wd[3:0];
                    xfer_bit  = wd[5];
                    mce_bit   = wd[6];
                end else if (off == crpe_pkg::OFF_DATA) begin
                    case (sel_index)
                        crpe_pkg::IDX_FORMAT:
                        begin
                            xtal = wd[0] ? XTAL_B : XTAL_A;
                            step = int'((xtal * 65536) /
                                        (longint'(div_tab[wd[3:1]]) * OUT_RATE));
                        end
                        crpe_pkg::IDX_CTRL:
                        begin
                            if (!playing)
                                phase = 0;
                            playing = ((wd & crpe_pkg::CTRL_MASK) == crpe_pkg::CTRL_RUN);
                        end
                        crpe_pkg::IDX_CNT_HI:
                            frames_left = int'({wd, ireg[crpe_pkg::IDX_CNT_LO]});
                        default: ;
                    endcase
                    if (sel_index != crpe_pkg::IDX_RO)
                        ireg[sel_index] = wd;
                end else if (off == crpe_pkg::OFF_STATUS) begin
                    status[0] = 1'b0;
                end
            end
            crpe_pkg::ACT_TICK:
            begin
                if (playing) begin
                    r.left_out  = scaled(hold_l, ireg[crpe_pkg::IDX_LGAIN]);
                    r.right_out = scaled(hold_r, ireg[crpe_pkg::IDX_RGAIN]);
                    acc = phase + step;
                    if (acc > crpe_pkg::PHASE_MAX)
                        acc = crpe_pkg::PHASE_MAX;
                    phase = acc;
                    if (phase >= PHASE_ONE) begin
                        phase -= PHASE_ONE;
                        if (frames_left < 0) begin
                            frames_left = int'({ireg[crpe_pkg::IDX_CNT_HI],
                                                ireg[crpe_pkg::IDX_CNT_LO]});
                            if (!status[0]) begin
                                status[0] = 1'b1;
                                r.irq_pulse = ireg[crpe_pkg::IDX_IRQ_EN][1];
                            end
                        end
                        case (ireg[crpe_pkg::IDX_FORMAT][6:4])
                            crpe_pkg::FMT_MONO8:
                            begin
                                hold_l = {dd[7:0] ^ crpe_pkg::SIGN_FLIP, 8'h00};
                                hold_r = hold_l;
                                r.dma_bytes_used = 3'd1;
                            end
                            crpe_pkg::FMT_STEREO8:
                            begin
                                hold_l = {dd[7:0] ^ crpe_pkg::SIGN_FLIP, 8'h00};
                                hold_r = {dd[15:8] ^ crpe_pkg::SIGN_FLIP, 8'h00};
                                r.dma_bytes_used = 3'd2;
                            end
                            crpe_pkg::FMT_MONO16:
                            begin
                                // high byte comes first on the DMA stream
                                hold_l = {dd[7:0], dd[15:8]};
                                hold_r = hold_l;
                                r.dma_bytes_used = 3'd2;
                            end
                            crpe_pkg::FMT_STEREO16:
                            begin
                                hold_l = {dd[7:0], dd[15:8]};
                                hold_r = {dd[23:16], dd[31:24]};
                                r.dma_bytes_used = 3'd4;
                            end
                            default: ;
                        endcase
                        frames_left--;
                        if (frames_left < COUNT_FLOOR)
                            frames_left = COUNT_FLOOR;
                    end
                end
            end
            default: ;
        endcase
        r.irq_number  = irq_line;
        r.dma_channel = dma_line;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        crpe_pkg::result_t want;
        if (!rst_n) begin
            mismatches  = 0;
            bus_cfg     = '0;
            sel_index   = '0;
            xfer_bit    = 1'b0;
            mce_bit     = 1'b1;
            ireg        = reg_boot;
            status      = crpe_pkg::STATUS_INIT;
            frames_left = 0;
            hold_l      = '0;
            hold_r      = '0;
            phase       = 0;
            step        = 0;
            playing     = 1'b0;
            irq_line    = crpe_pkg::IRQ_INIT;
            dma_line    = crpe_pkg::DMA_INIT;
            pending_responses.delete();
            awaited <= 0;
        end else begin
            if (s_tvalid && s_tready)
                pending_responses.push_back(codec_response(s_tuser, s_tdata[2:0],
                                                           s_tdata[10:3], s_tdata[42:11]));
            if (m_tvalid && m_tready) begin
                if (pending_responses.size() == 0) begin
                    mismatches++;
                    $error("result word %h with nothing expected", m_tdata);
                end else begin
                    want = pending_responses.pop_front();
                    check_field("read_data", want.read_data, m_tdata[7:0]);
                    check_field("left_out", want.left_out, m_tdata[23:8]);
                    check_field("right_out", want.right_out, m_tdata[39:24]);
                    check_field("dma_bytes_used", want.dma_bytes_used, m_tdata[42:40]);
                    check_field("irq_pulse", want.irq_pulse, m_tdata[43]);
                    check_field("irq_number", want.irq_number, m_tdata[47:44]);
                    check_field("dma_channel", want.dma_channel, m_tdata[49:48]);
                end
            end
            awaited <= pending_responses.size();
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the register playback codec
// Drives bus reads, bus writes and sample ticks: a directed opening, then
// randomized playback sessions (format, gains, frame count, irq enable, run)
// followed by tick bursts mixed with bus traffic and noise. Both stream sides
// stall at random; the checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] ACT_IGNORED  = 2'd3;
    localparam logic [2:0] OFF_CONFIG   = 3'd0;
    localparam logic [2:0] OFF_SPARE    = 3'd7;
    localparam int         WORD_TARGET  = 450;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         TIMEOUT_NS   = 1_000_000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    int   mismatches;
    int   awaited;
    int   words_sent = 0;
    logic steady     = 1'b0;

    logic [2:0] fmt_codes[4] = '{crpe_pkg::FMT_MONO8, crpe_pkg::FMT_STEREO8,
                                 crpe_pkg::FMT_MONO16, crpe_pkg::FMT_STEREO16};

    codec_register_playback_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    crpe_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 30);

    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // valid stays high from one word to the next unless a gap is drawn
    task automatic send_word(input logic [1:0] act, input logic [2:0] off,
                             input logic [7:0] wd, input logic [31:0] dd);
        while (!steady && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, dd, wd, off};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (act != ACT_IGNORED)
            words_sent++;
        steady <= (words_sent >= 240 && words_sent < 330);
    endtask

    task automatic bus_read(input logic [2:0] off);
        send_word(crpe_pkg::ACT_READ, off, 8'($urandom), $urandom);
    endtask

    task automatic bus_write(input logic [2:0] off, input logic [7:0] value);
        send_word(crpe_pkg::ACT_WRITE, off, value, $urandom);
    endtask

    task automatic tick(input logic [31:0] dd);
        send_word(crpe_pkg::ACT_TICK, 3'($urandom), 8'($urandom), dd);
    endtask

    // index word carries random flag bits along with the register number
    task automatic reg_write(input logic [3:0] idx, input logic [7:0] value);
        logic [7:0] sel;
        sel      = 8'($urandom);
        sel[3:0] = idx;
        bus_write(crpe_pkg::OFF_INDEX, sel);
        bus_write(crpe_pkg::OFF_DATA, value);
    endtask

    function automatic logic [7:0] gain_byte();
        logic [7:0] g;
        g      = 8'($urandom);
        g[7]   = ($urandom_range(0, 5) == 0);
        g[5:0] = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 12));
        return g;
    endfunction

    task automatic play_session();
        logic [7:0] fmt;
        logic [7:0] run;
        if ($urandom_range(0, 3) == 0)
            bus_write(3'($urandom_range(0, 3)), 8'($urandom));
        fmt = 8'($urandom);
        if ($urandom_range(0, 4) != 0)
            fmt[6:4] = fmt_codes[$urandom_range(0, 3)];
        reg_write(crpe_pkg::IDX_FORMAT, fmt);
        reg_write(crpe_pkg::IDX_LGAIN, gain_byte());
        reg_write(crpe_pkg::IDX_RGAIN, gain_byte());
        reg_write(crpe_pkg::IDX_CNT_LO, 8'($urandom_range(0, 6)));
        reg_write(crpe_pkg::IDX_CNT_HI, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
        reg_write(crpe_pkg::IDX_IRQ_EN, 8'($urandom));
        run = 8'($urandom);
        if ($urandom_range(0, 9) != 0)
            run = (run & ~crpe_pkg::CTRL_MASK) | crpe_pkg::CTRL_RUN;
        reg_write(crpe_pkg::IDX_CTRL, run);
        repeat ($urandom_range(8, 30)) begin
            case ($urandom_range(0, 9))
                7:       bus_read(3'($urandom));
                8:       bus_write(crpe_pkg::OFF_STATUS, 8'($urandom));
                9:       bus_write(3'($urandom), 8'($urandom));
                default: tick($urandom);
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            reg_write(crpe_pkg::IDX_CTRL, 8'($urandom) & ~crpe_pkg::CTRL_RUN);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic paused;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, idle tick, unused action and offset
        bus_read(OFF_CONFIG);
        bus_read(crpe_pkg::OFF_INDEX);
        bus_read(crpe_pkg::OFF_DATA);
        bus_read(crpe_pkg::OFF_STATUS);
        bus_read(OFF_SPARE);
        tick(32'hffff_ffff);
        send_word(ACT_IGNORED, 3'($urandom), 8'($urandom), $urandom);
        bus_write(3'd3, 8'hff);
        bus_read(3'd2);
        bus_write(OFF_SPARE, 8'h5a);
        // read-only register drops the write
        reg_write(crpe_pkg::IDX_RO, 8'h55);
        bus_read(crpe_pkg::OFF_DATA);
        // stereo 16-bit at the fastest step so the accumulator saturates
        reg_write(crpe_pkg::IDX_FORMAT, 8'h5a);
        reg_write(crpe_pkg::IDX_LGAIN, 8'h00);
        reg_write(crpe_pkg::IDX_RGAIN, 8'h3f);
        reg_write(crpe_pkg::IDX_CNT_LO, 8'h01);
        reg_write(crpe_pkg::IDX_CNT_HI, 8'h00);
        reg_write(crpe_pkg::IDX_IRQ_EN, 8'h02);
        reg_write(crpe_pkg::IDX_CTRL, crpe_pkg::CTRL_RUN);
        tick(32'h0080_0080);
        tick(32'hff7f_ff7f);
        repeat (4) tick($urandom);
        bus_read(crpe_pkg::OFF_STATUS);
        bus_write(crpe_pkg::OFF_STATUS, 8'h00);
        reg_write(crpe_pkg::IDX_RGAIN, 8'h80);
        tick($urandom);
        reg_write(crpe_pkg::IDX_CTRL, crpe_pkg::CTRL_MASK);

        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat (4)
                    send_word(2'($urandom), 3'($urandom), 8'($urandom), $urandom);
            end else begin
                play_session();
            end
            if (!paused && words_sent >= 200) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
